// ----- design/assert_macros.svh -----
// Assertion helpers used by the regulator core.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/cvccb_pkg.sv -----
// ----------------------------------------------------------------------------
// CV/CC boost regulator package
// Shared types and fixed constants for the regulator core and its registers.
// ----------------------------------------------------------------------------
package cvccb_pkg;

	// Request kinds carried on the input stream.
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_STORE = 2'd1,
		REQ_START = 2'd2
	} req_type_t;

	// Sense channel codes.
	typedef enum logic [1:0] {
		CH_NONE = 2'd0,
		CH_VOLT = 2'd1,
		CH_CURR = 2'd2
	} chan_t;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_TARGET_V = 2'd0;
	localparam logic [1:0] REG_TARGET_I = 2'd1;
	localparam logic [1:0] REG_RAMP     = 2'd2;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned BATT_W   = 16;
	localparam int unsigned RAMP_W   = 16;

	localparam logic [RAMP_W-1:0]   RAMP_RESET = 16'd100;
	localparam logic [SAMPLE_W-1:0] DUTY_TOP   = 10'd1022;

	// Current sense gain; the divide is done as a multiply by a rounded-up
	// reciprocal, exact for every 10-bit sample and any gain up to 64.
	localparam int unsigned CURRENT_GAIN = 11;
	localparam int unsigned DROP_SHIFT   = 16;
	localparam int unsigned RECIP_W      = DROP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] DROP_RECIP =
		RECIP_W'(((2 ** DROP_SHIFT) + CURRENT_GAIN - 1) / CURRENT_GAIN);

	// Configuration values seen by the core.
	typedef struct packed {
		logic [SAMPLE_W-1:0] target_voltage_code;
		logic [SAMPLE_W-1:0] target_current_code;
		logic [RAMP_W-1:0]   ramp_up_cycles;
	} cfg_t;

endpackage

// ----- design/cvccb_regs.sv -----
// ----------------------------------------------------------------------------
// CV/CC boost regulator registers
// APB-style register file holding the voltage and current targets and the
// ramp interval.
// ----------------------------------------------------------------------------
module cvccb_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cvccb_pkg::cfg_t      cfg
);

	logic [cvccb_pkg::SAMPLE_W-1:0] target_v_q;
	logic [cvccb_pkg::SAMPLE_W-1:0] target_i_q;
	logic [cvccb_pkg::RAMP_W-1:0]   ramp_q;
	logic                           wr_en;
	logic [1:0]                     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	// Register writes on the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_v_q <= '0;
			target_i_q <= '0;
			ramp_q     <= cvccb_pkg::RAMP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				cvccb_pkg::REG_TARGET_V: target_v_q <= pwdata[cvccb_pkg::SAMPLE_W-1:0];
				cvccb_pkg::REG_TARGET_I: target_i_q <= pwdata[cvccb_pkg::SAMPLE_W-1:0];
				cvccb_pkg::REG_RAMP:     ramp_q     <= pwdata[cvccb_pkg::RAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux; unmapped addresses read as zero.
	always_comb begin
		case (reg_idx)
			cvccb_pkg::REG_TARGET_V: prdata = {22'd0, target_v_q};
			cvccb_pkg::REG_TARGET_I: prdata = {22'd0, target_i_q};
			cvccb_pkg::REG_RAMP:     prdata = {16'd0, ramp_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.target_voltage_code = target_v_q;
	assign cfg.target_current_code = target_i_q;
	assign cfg.ramp_up_cycles      = ramp_q;

endmodule

// ----- design/cvcc_boost_pwm_regulator_core.sv -----
// ----------------------------------------------------------------------------
// CV/CC boost PWM regulator core
// Bang-bang constant-voltage/constant-current duty regulator with sense
// channel sequencing and sample storage.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per transfer: the kind in s_tuser
//   (tick, store sample, start conversion) and the ADC sample in s_tdata.
//   Every request yields exactly one result transfer on the output stream
//   with the duty, the channel started, both stored samples and the battery
//   code, all taken after the request's update.
//   The state updates at the input transfer; the result is registered in
//   the two-entry output buffer. One request per cycle is sustained while
//   the buffer has room; the path is one short update stage between the
//   state and the result register, with the current drop kept precomputed
//   beside the sample. The buffer takes one more request while the
//   receiver stalls; s_tready drops only when both entries hold results,
//   and no result is ever lost or repeated. Reset clears the duty, ramp
//   count, samples and channel sequence, sets the targets to zero and the
//   ramp interval to 100. The user writes registers through the APB port
//   only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cvcc_boost_pwm_regulator_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] pwm_duty, [11:10] acquire_channel, [21:12] measured_voltage,
	// [31:22] measured_current, [47:32] battery_voltage_code
	output logic [47:0] m_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned SW = cvccb_pkg::SAMPLE_W;
	localparam int unsigned BW = cvccb_pkg::BATT_W;
	localparam int unsigned RW = cvccb_pkg::RAMP_W;
	localparam int unsigned PW = SW + cvccb_pkg::RECIP_W;

	cvccb_pkg::cfg_t      cfg;
	cvccb_pkg::req_type_t req;
	cvccb_pkg::chan_t     last_q, last_n, started;

	logic [SW-1:0] duty_q, duty_n;
	logic [RW-1:0] ramp_cnt_q, ramp_cnt_n, ramp_inc;
	logic [SW-1:0] volt_q, volt_n;
	logic [SW-1:0] curr_q, curr_n;
	logic [SW-1:0] drop_q, drop_n;
	logic [SW-1:0] sample;
	logic [PW-1:0] drop_prod;
	logic [BW-1:0] batt_now, batt_n;
	logic          under, over;
	logic          in_xfer, out_pop;
	logic [47:0]   result;

	logic          out_valid_q, skid_valid_q;
	logic [47:0]   out_data_q, skid_data_q;

	cvccb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign req     = cvccb_pkg::req_type_t'(s_tuser);
	assign sample  = s_tdata[SW-1:0];
	assign in_xfer = s_tvalid & s_tready;
	assign out_pop = out_valid_q & m_tready;

	// Current drop for a newly stored current sample (reciprocal multiply).
	assign drop_prod = PW'(sample) * PW'(cvccb_pkg::DROP_RECIP);

	// Battery code and target comparison on the present state.
	assign batt_now = BW'(volt_q) - BW'(drop_q);
	assign under = (batt_now < BW'(cfg.target_voltage_code)) &&
		(curr_q < cfg.target_current_code);
	assign over = (batt_now > BW'(cfg.target_voltage_code)) ||
		(curr_q > cfg.target_current_code);
	assign ramp_inc = ramp_cnt_q + 1'b1;

	// Next state for the request at the input.
	always_comb begin
		duty_n     = duty_q;
		ramp_cnt_n = ramp_cnt_q;
		volt_n     = volt_q;
		curr_n     = curr_q;
		drop_n     = drop_q;
		last_n     = last_q;
		started    = cvccb_pkg::CH_NONE;
		case (req)
			cvccb_pkg::REQ_TICK: begin
				if (under) begin
					if (duty_q < cvccb_pkg::DUTY_TOP) begin
						if (ramp_inc == cfg.ramp_up_cycles) begin
							duty_n     = duty_q + 1'b1;
							ramp_cnt_n = '0;
						end else begin
							ramp_cnt_n = ramp_inc;
						end
					end else begin
						duty_n = '0;
					end
				end else if (over && (duty_q != '0)) begin
					duty_n = duty_q - 1'b1;
				end
			end
			cvccb_pkg::REQ_STORE: begin
				if (last_q == cvccb_pkg::CH_VOLT) begin
					volt_n = sample;
				end else if (last_q == cvccb_pkg::CH_CURR) begin
					curr_n = sample;
					drop_n = drop_prod[cvccb_pkg::DROP_SHIFT +: SW];
				end
			end
			cvccb_pkg::REQ_START: begin
				started = (last_q == cvccb_pkg::CH_VOLT) ? cvccb_pkg::CH_CURR :
					cvccb_pkg::CH_VOLT;
				last_n  = started;
			end
			default: ;
		endcase
	end

	// Result fields taken after the update.
	assign batt_n = BW'(volt_n) - BW'(drop_n);
	assign result = {batt_n, curr_n, volt_n, started, duty_n};

	// Regulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q     <= '0;
			ramp_cnt_q <= '0;
			volt_q     <= '0;
			curr_q     <= '0;
			drop_q     <= '0;
			last_q     <= cvccb_pkg::CH_NONE;
		end else if (in_xfer) begin
			duty_q     <= duty_n;
			ramp_cnt_q <= ramp_cnt_n;
			volt_q     <= volt_n;
			curr_q     <= curr_n;
			drop_q     <= drop_n;
			last_q     <= last_n;
		end
	end

	// Output register with a skid entry behind it.
	assign s_tready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_xfer) begin
				out_data_q <= result;
			end
		end else if (in_xfer) begin
			if (out_valid_q) begin
				skid_data_q <= result;
			end else begin
				out_data_q <= result;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks on the regulator and buffer logic.
	`ASSERT_CLK(a_duty_in_range, duty_q <= cvccb_pkg::DUTY_TOP, "duty above top")
	`ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
	`ASSERT_CLK(a_drop_bounded, drop_q <= curr_q, "current drop exceeds sample")
	`ASSERT_CLK(a_start_alternates,
		(in_xfer && (req == cvccb_pkg::REQ_START) && (last_q == cvccb_pkg::CH_VOLT))
		|=> (last_q == cvccb_pkg::CH_CURR), "channel sequence did not alternate")

endmodule

// ----- sim/cvcc_boost_pwm_regulator_checker.sv -----
// ----------------------------------------------------------------------------
// CV/CC boost regulator stream checker
// Watches the request stream, the result stream and the register port of the
// regulator core. It keeps its own copy of the regulator state, works out the
// reading that each accepted request must produce, and compares every result
// transfer field by field with the oldest reading still owed. Register writes
// update the local settings, and register reads are checked against them.
// ----------------------------------------------------------------------------
module cvcc_boost_pwm_regulator_checker
	import cvccb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] pwm_duty, [11:10] acquire_channel, [21:12] measured_voltage,
	// [31:22] measured_current, [47:32] battery_voltage_code
	input  logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          pending_count
);

	localparam int PRINT_LIMIT = 40;

	// One result transfer, in the order the fields sit in m_tdata.
	typedef struct packed {
		logic [BATT_W-1:0]   batt;
		logic [SAMPLE_W-1:0] curr;
		logic [SAMPLE_W-1:0] volt;
		logic [1:0]          channel;
		logic [SAMPLE_W-1:0] duty;
	} reading_t;

	// Local copy of the settings.
	logic [SAMPLE_W-1:0] volt_target;
	logic [SAMPLE_W-1:0] curr_target;
	logic [RAMP_W-1:0]   ramp_period;

	// Local copy of the regulator state.
	logic [SAMPLE_W-1:0] duty_q;
	logic [RAMP_W-1:0]   ramp_q;
	logic [SAMPLE_W-1:0] volt_q;
	logic [SAMPLE_W-1:0] curr_q;
	logic [1:0]          last_chan_q;

	reading_t expected_readings[$];

	// Prints one line for the first few mismatches and counts all of them.
	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Battery code: voltage sample less the current drop, wrapping at 16 bits.
	function automatic logic [BATT_W-1:0] battery_of(input logic [SAMPLE_W-1:0] volt,
			input logic [SAMPLE_W-1:0] curr);
		logic [BATT_W-1:0] drop;
		drop = BATT_W'(curr) / BATT_W'(CURRENT_GAIN);
		return BATT_W'(volt) - drop;
	endfunction

	// Applies one request to the local state and returns the reading it yields.
	function automatic reading_t apply_request(input logic [1:0] req,
			input logic [SAMPLE_W-1:0] sample);
		reading_t          r;
		logic [1:0]        started;
		logic [BATT_W-1:0] batt;
		logic [RAMP_W-1:0] next_count;
		started = CH_NONE;
		if (req == REQ_TICK) begin
			batt = battery_of(volt_q, curr_q);
			if (batt < BATT_W'(volt_target) && curr_q < curr_target) begin
				// Under target: ramp up, or wrap from the top back to zero.
				if (duty_q < DUTY_TOP) begin
					next_count = ramp_q + 1'b1;
					if (next_count == ramp_period) begin
						duty_q = duty_q + 1'b1;
						ramp_q = '0;
					end else begin
						ramp_q = next_count;
					end
				end else begin
					duty_q = '0;
				end
			end else if (batt > BATT_W'(volt_target) || curr_q > curr_target) begin
				if (duty_q != '0)
					duty_q = duty_q - 1'b1;
			end
		end else if (req == REQ_STORE) begin
			// A sample with no channel started yet is dropped.
			if (last_chan_q == CH_VOLT)
				volt_q = sample;
			else if (last_chan_q == CH_CURR)
				curr_q = sample;
		end else if (req == REQ_START) begin
			started = (last_chan_q == CH_VOLT) ? CH_CURR : CH_VOLT;
			last_chan_q = started;
		end
		r.duty = duty_q;
		r.channel = started;
		r.volt = volt_q;
		r.curr = curr_q;
		r.batt = battery_of(volt_q, curr_q);
		return r;
	endfunction

	// Compare results, queue new expectations and follow the register port.
	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		logic [31:0] reg_value;
		if (!arst_n) begin
			volt_target <= '0;
			curr_target <= '0;
			ramp_period <= RAMP_RESET;
			duty_q <= '0;
			ramp_q <= '0;
			volt_q <= '0;
			curr_q <= '0;
			last_chan_q <= CH_NONE;
			expected_readings.delete();
			pending_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = reading_t'(m_tdata);
				if (expected_readings.size() == 0) begin
					note_mismatch("result transfer with nothing owed, duty", got.duty, 0);
				end else begin
					want = expected_readings.pop_front();
					if (got.duty !== want.duty)
						note_mismatch("pwm_duty", got.duty, want.duty);
					if (got.channel !== want.channel)
						note_mismatch("acquire_channel", got.channel, want.channel);
					if (got.volt !== want.volt)
						note_mismatch("measured_voltage", got.volt, want.volt);
					if (got.curr !== want.curr)
						note_mismatch("measured_current", got.curr, want.curr);
					if (got.batt !== want.batt)
						note_mismatch("battery_voltage_code", got.batt, want.batt);
				end
			end
			if (s_tvalid && s_tready)
				expected_readings.push_back(apply_request(s_tuser, s_tdata[SAMPLE_W-1:0]));
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_TARGET_V: volt_target <= pwdata[SAMPLE_W-1:0];
						REG_TARGET_I: curr_target <= pwdata[SAMPLE_W-1:0];
						REG_RAMP:     ramp_period <= pwdata[RAMP_W-1:0];
						default: ;
					endcase
				end else begin
					// Unmapped addresses read as zero.
					case (paddr[3:2])
						REG_TARGET_V: reg_value = 32'(volt_target);
						REG_TARGET_I: reg_value = 32'(curr_target);
						REG_RAMP:     reg_value = 32'(ramp_period);
						default:      reg_value = '0;
					endcase
					if (prdata !== reg_value)
						note_mismatch("register read", prdata, reg_value);
				end
			end
			pending_count <= expected_readings.size();
		end
	end

endmodule

// ----- sim/cvcc_boost_pwm_regulator_core_test.sv -----
// ----------------------------------------------------------------------------
// CV/CC boost regulator core testbench
// Drives requests and register writes into the regulator core and lets the
// stream checker judge every result. A short directed run covers the channel
// sequence, dropped samples, the unused request code, battery code wrap and
// the duty floor; then random measurement cycles run under several settings
// and idle patterns.
// ----------------------------------------------------------------------------
module cvcc_boost_pwm_regulator_core_test;
	import cvccb_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 48;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 85;

	// Request code with no meaning, and the register index past the last one.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] REG_SPARE  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [9:0] adc_sample, [15:10] zero
	logic [1:0]  s_tuser = '0;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [9:0] pwm_duty, [11:10] acquire_channel, [21:12] measured_voltage,
	// [31:22] measured_current, [47:32] battery_voltage_code
	logic [47:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int send_idle_pct = 10;
	int recv_idle_pct = 87;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatch_count;
	int pending_count;

	cvcc_boost_pwm_regulator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cvcc_boost_pwm_regulator_checker regulator_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	// Clock.
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Result receiver: random stalls, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			m_tready <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run after too long with no transfer anywhere.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one request and holds it until the transfer.
	task automatic send_req(input logic [1:0] req, input logic [9:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {6'b0, sample};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Stops offering and waits until every owed result has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic read_reg(input logic [1:0] index);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {index, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all three registers, with junk above each field, and reads them back.
	task automatic apply_settings(input logic [9:0] volt_target,
			input logic [9:0] curr_target, input logic [15:0] ramp);
		write_reg(REG_TARGET_V, ($urandom() & 32'hFFFF_FC00) | {22'b0, volt_target});
		write_reg(REG_TARGET_I, ($urandom() & 32'hFFFF_FC00) | {22'b0, curr_target});
		write_reg(REG_RAMP, ($urandom() & 32'hFFFF_0000) | {16'b0, ramp});
		read_reg(REG_TARGET_V);
		read_reg(REG_TARGET_I);
		read_reg(REG_RAMP);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// Samples lean toward the ends of the range.
	function automatic logic [9:0] pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return 10'd0;
		if (roll < 30)
			return 10'h3FF;
		return 10'($urandom_range(1023));
	endfunction

	function automatic logic [9:0] pick_target();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return 10'd0;
		if (roll < 45)
			return 10'h3FF;
		return 10'($urandom_range(1023));
	endfunction

	// Mostly full measurement cycles (both channels sampled, then ticks),
	// with some stray requests of any kind mixed in.
	task automatic run_random(input int count);
		int sent;
		int ticks;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 80) begin
				ticks = $urandom_range(1, 6);
				send_req(REQ_START, pick_sample());
				send_req(REQ_STORE, pick_sample());
				send_req(REQ_START, pick_sample());
				send_req(REQ_STORE, pick_sample());
				repeat (ticks) send_req(REQ_TICK, pick_sample());
				sent += 4 + ticks;
			end else begin
				send_req(2'($urandom_range(3)), pick_sample());
				sent++;
			end
		end
	endtask

	// Main sequence.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		read_reg(REG_TARGET_V);
		read_reg(REG_TARGET_I);
		read_reg(REG_RAMP);

		// Directed part at reset settings: dropped store, idle tick, unused
		// code, channel alternation, full-scale samples, battery code wrap.
		send_req(REQ_STORE, 10'h3FF);
		send_req(REQ_TICK, 10'h3FF);
		send_req(REQ_UNUSED, 10'h3FF);
		send_req(REQ_START, 10'd0);
		send_req(REQ_STORE, 10'h3FF);
		send_req(REQ_START, 10'd0);
		send_req(REQ_STORE, 10'h3FF);
		send_req(REQ_TICK, 10'd0);
		send_req(REQ_START, 10'h3FF);
		send_req(REQ_STORE, 10'd0);
		send_req(REQ_TICK, 10'd0);

		// Directed part at top targets: duty ramps, then holds at the target.
		wait_drained();
		apply_settings(10'h3FF, 10'h3FF, 16'd1);
		write_reg(REG_SPARE, $urandom());
		send_req(REQ_START, 10'h155);
		send_req(REQ_STORE, 10'd0);
		send_req(REQ_TICK, 10'h2AA);
		send_req(REQ_TICK, 10'h155);
		send_req(REQ_START, 10'd0);
		send_req(REQ_STORE, 10'h3FF);
		send_req(REQ_TICK, 10'd0);
		send_req(REQ_START, 10'd0);
		send_req(REQ_STORE, 10'd1);
		send_req(REQ_TICK, 10'h3FF);
		send_req(REQ_UNUSED, 10'd0);

		// Sender idles lightly, receiver stalls heavily.
		run_random(PHASE_ITEMS / 2);
		wait_drained();
		run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
		wait_drained();
		apply_settings(pick_target(), pick_target(), 16'($urandom_range(1, 8)));
		run_random(PHASE_ITEMS);

		// Sender idles heavily, receiver stalls lightly.
		wait_drained();
		set_idling(87, 10);
		apply_settings(pick_target(), pick_target(), 16'hFFFF);
		run_random(PHASE_ITEMS);
		wait_drained();
		apply_settings(pick_target(), pick_target(), 16'($urandom()));
		run_random(PHASE_ITEMS);

		// No idling; one long receiver hold-off while requests keep coming.
		wait_drained();
		set_idling(0, 0);
		apply_settings(10'h3FF, pick_target(), 16'd3);
		hold_asked <= hold_asked + 1;
		run_random(PHASE_ITEMS);
		wait_drained();
		apply_settings(pick_target(), pick_target(), 16'($urandom_range(1, 8)));
		run_random(PHASE_ITEMS);

		wait_drained();
		if (mismatch_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- cvcc_boost_pwm_regulator_core.f -----
+incdir+design
design/cvccb_pkg.sv
design/cvccb_regs.sv
design/cvcc_boost_pwm_regulator_core.sv
sim/cvcc_boost_pwm_regulator_checker.sv
sim/cvcc_boost_pwm_regulator_core_test.sv
